// ===== rtl/fprs_pkg.sv =====
// shared types and constants for the fpu register stack
package fprs_pkg;

    localparam int MANT_W     = 64;
    localparam int SE_W       = 16;
    localparam int VAL_W      = MANT_W + SE_W;
    localparam int FLAG_W     = 6;
    localparam int IDX_W      = 3;
    localparam int TAG_W      = 2;
    localparam int OP_W       = 3;
    localparam int DEPTH_DEF  = 8;

    localparam logic [FLAG_W-1:0] MASK_RESET = 6'h3F;
    localparam logic [TAG_W-1:0]  TAG_LIVE   = 2'd0;
    localparam logic [TAG_W-1:0]  TAG_FREE   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_RAISE = 3'd4,
        OP_CLEAR = 3'd5,
        OP_INIT  = 3'd6
    } t_op;

    // register file access for one request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // result fields captured when a request is taken
    typedef struct packed {
        logic              sel;
        logic [TAG_W-1:0]  reg_tag;
        logic [IDX_W-1:0]  top;
        logic [FLAG_W-1:0] flags;
        logic              fault;
        logic              summary;
    } t_meta;

endpackage

// ===== rtl/fprs_ifs.sv =====
// request and response channel interfaces
interface fprs_in_if;
    import fprs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  reg_index;
    logic [MANT_W-1:0] in_mantissa;
    logic [SE_W-1:0]   in_sign_exponent;
    logic [FLAG_W-1:0] raise_flags;

    modport source (
        output valid, op, reg_index, in_mantissa, in_sign_exponent, raise_flags,
        input  ready
    );
    modport sink (
        input  valid, op, reg_index, in_mantissa, in_sign_exponent, raise_flags,
        output ready
    );
endinterface

interface fprs_out_if;
    import fprs_pkg::*;

    logic              valid;
    logic              ready;
    logic [MANT_W-1:0] out_mantissa;
    logic [SE_W-1:0]   out_sign_exponent;
    logic [TAG_W-1:0]  reg_tag;
    logic [IDX_W-1:0]  top_index;
    logic [FLAG_W-1:0] exception_flags;
    logic              fault_flag;
    logic              summary_flag;

    modport source (
        output valid, out_mantissa, out_sign_exponent, reg_tag, top_index,
               exception_flags, fault_flag, summary_flag,
        input  ready
    );
    modport sink (
        input  valid, out_mantissa, out_sign_exponent, reg_tag, top_index,
               exception_flags, fault_flag, summary_flag,
        output ready
    );
endinterface

// ===== rtl/fprs_ram.sv =====
// generic single write port ram with registered read
module fprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fprs_ctrl.sv =====
// stack control: top pointer, tags, written bits, flags and mask
module fprs_ctrl #(
    parameter int STACK_DEPTH = fprs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [fprs_pkg::OP_W-1:0]   i_op,
    input  logic [fprs_pkg::IDX_W-1:0]  i_reg_index,
    input  logic [fprs_pkg::FLAG_W-1:0] i_raise_flags,
    input  logic                        i_cfg_we,
    input  logic [fprs_pkg::FLAG_W-1:0] i_cfg_wdata,
    output fprs_pkg::t_ram_req          o_ram,
    output fprs_pkg::t_meta             o_meta
);
    import fprs_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_V = (IDX_W+1)'(STACK_DEPTH);
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(STACK_DEPTH - 1);

    logic [IDX_W-1:0]  r_top,   n_top;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              r_fault, n_fault;
    logic              r_summary, n_summary;
    logic [FLAG_W-1:0] r_mask,  n_mask;
    logic              r_empty [STACK_DEPTH];
    logic              n_empty [STACK_DEPTH];
    logic              r_valid [STACK_DEPTH];
    logic              n_valid [STACK_DEPTH];
    t_meta             r_meta,  n_meta;

    t_op              op;
    logic             in_range;
    logic [IDX_W-1:0] p_push;
    logic [IDX_W-1:0] p_idx;
    logic [IDX_W-1:0] p_tag;
    logic             sel;

    // (top + i) mod depth, with i below depth
    function automatic logic [IDX_W-1:0] phys_of(input logic [IDX_W-1:0] top,
                                                 input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] sum;
        sum = {1'b0, top} + {1'b0, idx};
        if (sum >= DEPTH_V) begin
            sum = sum - DEPTH_V;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign op       = t_op'(i_op);
    assign in_range = {1'b0, i_reg_index} < DEPTH_V;
    assign p_push   = (r_top == '0) ? LAST : r_top - 1'b1;
    assign p_idx    = phys_of(r_top, i_reg_index);

    always_comb begin
        n_top     = r_top;
        n_flags   = r_flags;
        n_fault   = r_fault;
        n_summary = r_summary;
        n_mask    = i_cfg_we ? i_cfg_wdata : r_mask;
        n_empty   = r_empty;
        n_valid   = r_valid;
        sel       = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = p_idx;
        o_ram.re    = i_accept;
        o_ram.raddr = (op == OP_POP) ? r_top : p_idx;
        if (i_accept) begin
            case (op)
                OP_PUSH: begin
                    if (!r_empty[p_push[AW-1:0]]) begin
                        n_fault   = 1'b1;
                        n_summary = 1'b1;
                    end else begin
                        n_top                    = p_push;
                        n_empty[p_push[AW-1:0]]  = 1'b0;
                        n_valid[p_push[AW-1:0]]  = 1'b1;
                        o_ram.we                 = 1'b1;
                        o_ram.waddr              = p_push;
                    end
                end
                OP_POP: begin
                    if (r_empty[r_top[AW-1:0]]) begin
                        n_fault   = 1'b1;
                        n_summary = 1'b1;
                    end else begin
                        sel                     = r_valid[r_top[AW-1:0]];
                        n_empty[r_top[AW-1:0]]  = 1'b1;
                        n_top = (r_top == LAST) ? '0 : r_top + 1'b1;
                    end
                end
                OP_READ: begin
                    if (in_range) begin
                        sel = r_valid[p_idx[AW-1:0]];
                    end
                end
                OP_WRITE: begin
                    if (in_range) begin
                        n_empty[p_idx[AW-1:0]] = 1'b0;
                        n_valid[p_idx[AW-1:0]] = 1'b1;
                        o_ram.we               = 1'b1;
                    end
                end
                OP_RAISE: begin
                    n_flags = r_flags | i_raise_flags;
                    if ((i_raise_flags & ~r_mask) != '0) begin
                        n_summary = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_flags   = '0;
                    n_fault   = 1'b0;
                    n_summary = 1'b0;
                end
                OP_INIT: begin
                    n_top     = '0;
                    n_flags   = '0;
                    n_fault   = 1'b0;
                    n_summary = 1'b0;
                    n_mask    = MASK_RESET;
                    for (int k = 0; k < STACK_DEPTH; k++) begin
                        n_empty[k] = 1'b1;
                        n_valid[k] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // tag of st(i) as it stands after this request
    assign p_tag = phys_of(n_top, i_reg_index);

    always_comb begin
        n_meta.sel     = sel;
        n_meta.reg_tag = (in_range && !n_empty[p_tag[AW-1:0]]) ? TAG_LIVE : TAG_FREE;
        n_meta.top     = n_top;
        n_meta.flags   = n_flags;
        n_meta.fault   = n_fault;
        n_meta.summary = n_summary;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_flags   <= '0;
            r_fault   <= 1'b0;
            r_summary <= 1'b0;
            r_mask    <= MASK_RESET;
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_empty[k] <= 1'b1;
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_top     <= n_top;
            r_flags   <= n_flags;
            r_fault   <= n_fault;
            r_summary <= n_summary;
            r_mask    <= n_mask;
            r_empty   <= n_empty;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_meta <= n_meta;
        end
    end

    assign o_meta = r_meta;
endmodule

// ===== rtl/fpu_register_stack_with_tags_core.sv =====
// top level of the tagged fpu register stack
// Eight-entry (STACK_DEPTH) 80-bit register stack with a rotating top
// pointer, per-register tags and sticky exception flags. One request is
// taken per clock while the response register is free or being taken,
// and its response appears in the next cycle. That rate is set by the
// single register file access per request (one write port, one registered
// read port) plus the pointer and tag update done in the same cycle. The
// response register frees as it is taken, so a new request is taken while
// a response is handed over.
// Push onto a full slot or pop from an empty top sets the stack fault
// and error summary and changes nothing else. Reads of a slot that was
// never written return zero. The user must write the exception mask through
// i_cfg_we/i_cfg_wdata only while no request is in flight; the block does not enforce it.
module fpu_register_stack_with_tags_core #(
    parameter int STACK_DEPTH = fprs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fprs_in_if.sink                     i_req,
    fprs_out_if.source                  o_rsp,
    input  logic                        i_cfg_we,
    input  logic [fprs_pkg::FLAG_W-1:0] i_cfg_wdata
);
    import fprs_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic             accept;
    logic             r_out_valid;
    t_ram_req         ram_req;
    t_meta            meta;
    logic [VAL_W-1:0] rdata;

    // response register frees when it is empty or being taken
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // pointer, tags, flags and mask
    fprs_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_req.op),
        .i_reg_index   (i_req.reg_index),
        .i_raise_flags (i_req.raise_flags),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_ram         (ram_req),
        .o_meta        (meta)
    );

    // register file: significand in the upper bits, sign/exponent below
    fprs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr[AW-1:0]),
        .i_wdata ({i_req.in_mantissa, i_req.in_sign_exponent}),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // value fields only for a good pop or an in-range read of a written slot
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.out_mantissa      = meta.sel ? rdata[VAL_W-1:SE_W] : '0;
    assign o_rsp.out_sign_exponent = meta.sel ? rdata[SE_W-1:0] : '0;
    assign o_rsp.reg_tag           = meta.reg_tag;
    assign o_rsp.top_index         = meta.top;
    assign o_rsp.exception_flags   = meta.flags;
    assign o_rsp.fault_flag        = meta.fault;
    assign o_rsp.summary_flag      = meta.summary;

    // a taken request always yields a response next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp.valid)
        else $error("no response after taken request");

    // clear wipes all sticky status
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.op == OP_CLEAR)) |=>
        (!o_rsp.fault_flag && !o_rsp.summary_flag && (o_rsp.exception_flags == '0)))
        else $error("status not cleared");

    // initialize leaves an empty stack with top at zero and no value
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.op == OP_INIT)) |=>
        ((o_rsp.top_index == '0) && (o_rsp.reg_tag == TAG_FREE) &&
         (o_rsp.out_mantissa == '0)))
        else $error("initialize left state behind");
endmodule
